@@ sv/modbus_register_server_assert.svh @@
// Assertion macros shared by the Modbus register server modules.
`ifndef MODBUS_REGISTER_SERVER_ASSERT_SVH
`define MODBUS_REGISTER_SERVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MBRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modbus register server assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MBRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modbus register server assertion failed");

`endif

@@ sv/mbrs_pkg.sv @@
// Types and constants of the Modbus register server.
package mbrs_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_NET   = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Modbus function codes and exception codes.
    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_EXC_BIT      = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FN   = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0] EXC_NONE         = 8'h00;

    // Result item kinds and MBAP lengths.
    localparam logic       KIND_HEADER = 1'b0;
    localparam logic       KIND_DATA   = 1'b1;
    localparam logic [7:0] LEN_BASE    = 8'd3;
    localparam logic [7:0] LEN_EXC     = 8'd3;
    localparam logic [7:0] LEN_ECHO    = 8'd6;

    // Configuration register indexes and reset values.
    localparam int         CFG_IDX_W       = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ID     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_PORT = 4'd1;
    localparam logic [7:0]  UNIT_ID_RST     = 8'd1;
    localparam logic [15:0] LISTEN_PORT_RST = 16'd502;

    // Job queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Operation that the back end carries out.
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CLEAR,
        OP_READ,
        OP_WRITE,
        OP_EXC,
        OP_ECHO
    } t_op;

    // One classified job.
    typedef struct packed {
        t_op         op;
        logic [7:0]  func;
        logic [7:0]  exc;
        logic [15:0] addr;
        logic [15:0] value;
        logic [15:0] tid;
        logic [7:0]  unit;
        logic        wr;
    } t_job;

    // One result item.
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  resp_function;
        logic [7:0]  count_or_exception;
        logic [15:0] echo_address;
        logic [15:0] echo_value;
        logic [7:0]  mbap_length;
        logic [15:0] reply_transaction;
        logic [7:0]  reply_unit;
        logic [15:0] register_word;
        logic        dirty_flag;
        logic        is_last;
    } t_rsp;

endpackage

@@ sv/mbrs_if.sv @@
// Channel interfaces: request, response and configuration write.
interface mbrs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] dest_port;
    logic [7:0]  unit_ident;
    logic [7:0]  func_code;
    logic [15:0] start_address;
    logic [15:0] value_or_quantity;
    logic [15:0] transaction_ident;
    logic        load_writable;

    modport source (
        output valid, cmd, dest_port, unit_ident, func_code, start_address,
               value_or_quantity, transaction_ident, load_writable,
        input  ready
    );
    modport sink (
        input  valid, cmd, dest_port, unit_ident, func_code, start_address,
               value_or_quantity, transaction_ident, load_writable,
        output ready
    );
endinterface

interface mbrs_rsp_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  resp_function;
    logic [7:0]  count_or_exception;
    logic [15:0] echo_address;
    logic [15:0] echo_value;
    logic [7:0]  mbap_length;
    logic [15:0] reply_transaction;
    logic [7:0]  reply_unit;
    logic [15:0] register_word;
    logic        dirty_flag;
    logic        is_last;

    modport source (
        output valid, item_kind, resp_function, count_or_exception, echo_address,
               echo_value, mbap_length, reply_transaction, reply_unit,
               register_word, dirty_flag, is_last,
        input  ready
    );
    modport sink (
        input  valid, item_kind, resp_function, count_or_exception, echo_address,
               echo_value, mbap_length, reply_transaction, reply_unit,
               register_word, dirty_flag, is_last,
        output ready
    );
endinterface

interface mbrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbrs_pkg::CFG_IDX_W-1:0] reg_index;
    logic [15:0]                    wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ sv/modbus_register_server.sv @@
// Top level of the Modbus register server.
//
//  Channel   Role      Transaction carries
//  i_req     sink      parsed request or host command
//  i_cfg     sink      configuration register index and write data
//  o_rsp     source    reply header or register data word
//
// The back end does a host command in S_IDLE, an exception or read header in
// S_HEAD, a single write in S_WCHK (table lookup) then S_HEAD (reply), and a
// read in S_HEAD and then S_DATA, reading one table entry per cycle unless
// o_rsp stalls. Reset is synchronous; per-entry valid bits clear the table.
// The front end keeps accepting into a two-entry queue while the back end
// stalls on o_rsp; a finished item waits in the output register.
module modbus_register_server #(
    parameter int REG_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbrs_req_if.sink    i_req,
    mbrs_cfg_if.sink    i_cfg,
    mbrs_rsp_if.source  o_rsp
);

    logic           w_push;
    logic           w_push_ready;
    mbrs_pkg::t_job w_push_job;
    logic           w_job_valid;
    mbrs_pkg::t_job w_job;
    logic           w_job_pop;

    // Filtering and classification.
    mbrs_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    // Job queue.
    mbrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_ready (w_push_ready),
        .o_valid (w_job_valid),
        .o_job   (w_job),
        .i_pop   (w_job_pop)
    );

    // Table and reply generation.
    mbrs_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_rsp       (o_rsp)
    );

endmodule

@@ sv/mbrs_front.sv @@
// Front end: configuration registers, request filtering and classification.
module mbrs_front #(
    parameter int REG_COUNT = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mbrs_req_if.sink        i_req,
    mbrs_cfg_if.sink        i_cfg,
    input  logic            i_push_ready,
    output logic            o_push,
    output mbrs_pkg::t_job  o_job
);

    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);

    logic [7:0]  r_unit_id;
    logic [15:0] r_listen_port;
    logic [16:0] w_sum;
    logic        w_keep;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id     <= mbrs_pkg::UNIT_ID_RST;
            r_listen_port <= mbrs_pkg::LISTEN_PORT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                mbrs_pkg::CFG_UNIT_ID:     r_unit_id     <= i_cfg.wdata[7:0];
                mbrs_pkg::CFG_LISTEN_PORT: r_listen_port <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // Read range end, taken without wrap.
    assign w_sum = {1'b0, i_req.start_address} + {1'b0, i_req.value_or_quantity};

    // Classify the request into a job; dropped requests are accepted and discarded.
    always_comb begin
        o_job.op    = mbrs_pkg::OP_EXC;
        o_job.func  = i_req.func_code;
        o_job.exc   = mbrs_pkg::EXC_NONE;
        o_job.addr  = i_req.start_address;
        o_job.value = i_req.value_or_quantity;
        o_job.tid   = i_req.transaction_ident;
        o_job.unit  = i_req.unit_ident;
        o_job.wr    = i_req.load_writable;
        w_keep      = 1'b0;
        unique case (i_req.cmd)
            mbrs_pkg::CMD_LOAD: begin
                o_job.op = mbrs_pkg::OP_LOAD;
                w_keep   = ({1'b0, i_req.start_address} < REG_LIMIT);
            end
            mbrs_pkg::CMD_CLEAR: begin
                o_job.op = mbrs_pkg::OP_CLEAR;
                w_keep   = 1'b1;
            end
            mbrs_pkg::CMD_NET: begin
                w_keep = (i_req.dest_port == r_listen_port) &&
                         (i_req.unit_ident == r_unit_id);
                if (i_req.func_code == mbrs_pkg::FN_READ_HOLDING ||
                    i_req.func_code == mbrs_pkg::FN_READ_INPUT) begin
                    if (w_sum <= REG_LIMIT) begin
                        o_job.op = mbrs_pkg::OP_READ;
                    end else begin
                        o_job.exc = mbrs_pkg::EXC_ILLEGAL_ADDR;
                    end
                end else if (i_req.func_code == mbrs_pkg::FN_WRITE_SINGLE) begin
                    if ({1'b0, i_req.start_address} < REG_LIMIT) begin
                        o_job.op = mbrs_pkg::OP_WRITE;
                    end else begin
                        o_job.exc = mbrs_pkg::EXC_ILLEGAL_ADDR;
                    end
                end else begin
                    o_job.exc = mbrs_pkg::EXC_ILLEGAL_FN;
                end
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign i_req.ready = i_push_ready;
    assign o_push      = i_req.valid && i_push_ready && w_keep;

endmodule

@@ sv/mbrs_queue.sv @@
// Short job queue between the front end and the back end.
module mbrs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbrs_pkg::t_job  i_job,
    output logic            o_ready,
    output logic            o_valid,
    output mbrs_pkg::t_job  o_job,
    input  logic            i_pop
);

    `include "modbus_register_server_assert.svh"

    mbrs_pkg::t_job                r_slot [mbrs_pkg::Q_DEPTH];
    logic [mbrs_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [mbrs_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [mbrs_pkg::Q_CNT_W-1:0]  r_count;

    assign o_ready = (r_count != mbrs_pkg::Q_CNT_W'(mbrs_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MBRS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= mbrs_pkg::Q_CNT_W'(mbrs_pkg::Q_DEPTH))
    `MBRS_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, r_count != '0)

endmodule

@@ sv/mbrs_back.sv @@
// Back end: register table, write check, reply sequencing and output register.
module mbrs_back #(
    parameter int REG_COUNT = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  mbrs_pkg::t_job  i_job,
    output logic            o_job_pop,
    mbrs_rsp_if.source      o_rsp
);

    `include "modbus_register_server_assert.svh"

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CNT_W = $clog2(REG_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WCHK = 4'b0010,
        S_HEAD = 4'b0100,
        S_DATA = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    mbrs_pkg::t_job  r_job, n_job;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic            r_dirty, n_dirty;
    mbrs_pkg::t_rsp  r_out, n_out;
    logic            r_out_vld;
    logic            w_out_load;
    logic            w_slot;

    // Table: bit 16 is the writable mark, bits 15:0 the value.
    logic [16:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [16:0]          r_rd;
    logic                 r_rd_vld;
    logic                 w_we;
    logic [IDX_W-1:0]     w_wa;
    logic [16:0]          w_wd;

    mbrs_pkg::t_rsp  w_head;
    mbrs_pkg::t_rsp  w_data;
    logic [7:0]      w_cnt;

    assign w_slot = !r_out_vld || o_rsp.ready;

    // Header item built from the current job.
    always_comb begin
        w_cnt                      = {r_job.value[6:0], 1'b0};
        w_head.item_kind           = mbrs_pkg::KIND_HEADER;
        w_head.resp_function       = r_job.func;
        w_head.count_or_exception  = mbrs_pkg::EXC_NONE;
        w_head.echo_address        = '0;
        w_head.echo_value          = '0;
        w_head.mbap_length         = mbrs_pkg::LEN_EXC;
        w_head.reply_transaction   = r_job.tid;
        w_head.reply_unit          = r_job.unit;
        w_head.register_word       = '0;
        w_head.dirty_flag          = r_dirty;
        w_head.is_last             = 1'b1;
        case (r_job.op)
            mbrs_pkg::OP_READ: begin
                w_head.count_or_exception = w_cnt;
                w_head.mbap_length        = mbrs_pkg::LEN_BASE + w_cnt;
                w_head.is_last            = (r_rem == '0);
            end
            mbrs_pkg::OP_ECHO: begin
                w_head.echo_address = r_job.addr;
                w_head.echo_value   = r_job.value;
                w_head.mbap_length  = mbrs_pkg::LEN_ECHO;
            end
            default: begin
                w_head.resp_function      = r_job.func | mbrs_pkg::FN_EXC_BIT;
                w_head.count_or_exception = r_job.exc;
            end
        endcase
    end

    // Data item: header fields of the read plus one table word.
    always_comb begin
        w_data               = w_head;
        w_data.item_kind     = mbrs_pkg::KIND_DATA;
        w_data.register_word = r_rd_vld ? r_rd[15:0] : 16'd0;
        w_data.is_last       = (r_rem == CNT_W'(1));
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_ptr      = r_ptr;
        n_rem      = r_rem;
        n_dirty    = r_dirty;
        n_out      = r_out;
        w_out_load = 1'b0;
        o_job_pop  = 1'b0;
        w_we       = 1'b0;
        w_wa       = r_ptr;
        w_wd       = {r_job.wr, r_job.value};
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_ptr     = i_job.addr[IDX_W-1:0];
                    n_rem     = i_job.value[CNT_W-1:0];
                    case (i_job.op)
                        mbrs_pkg::OP_LOAD: begin
                            w_we = 1'b1;
                            w_wa = i_job.addr[IDX_W-1:0];
                            w_wd = {i_job.wr, i_job.value};
                        end
                        mbrs_pkg::OP_CLEAR: n_dirty = 1'b0;
                        mbrs_pkg::OP_WRITE: n_state = S_WCHK;
                        default:            n_state = S_HEAD;
                    endcase
                end
            end
            S_WCHK: begin
                // The table entry of the write address is in r_rd now.
                if (r_rd_vld && r_rd[16]) begin
                    w_we     = 1'b1;
                    w_wd     = {1'b1, r_job.value};
                    n_dirty  = 1'b1;
                    n_job.op = mbrs_pkg::OP_ECHO;
                end else begin
                    n_job.op  = mbrs_pkg::OP_EXC;
                    n_job.exc = mbrs_pkg::EXC_ILLEGAL_FN;
                end
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (w_slot) begin
                    w_out_load = 1'b1;
                    n_out      = w_head;
                    if (r_job.op == mbrs_pkg::OP_READ && r_rem != '0) begin
                        n_state = S_DATA;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DATA: begin
                if (w_slot) begin
                    w_out_load = 1'b1;
                    n_out      = w_data;
                    n_rem      = r_rem - 1'b1;
                    n_ptr      = IDX_W'(r_ptr + 1'b1);
                    if (r_rem == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dirty   <= 1'b0;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_we) begin
                r_vld[w_wa] <= 1'b1;
            end
        end
    end

    // Job, walk pointer and output payload.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_ptr <= n_ptr;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    // Table memory; the read follows the next walk pointer.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd     <= r_mem[n_ptr];
        r_rd_vld <= r_vld[n_ptr];
    end

    assign o_rsp.valid              = r_out_vld;
    assign o_rsp.item_kind          = r_out.item_kind;
    assign o_rsp.resp_function      = r_out.resp_function;
    assign o_rsp.count_or_exception = r_out.count_or_exception;
    assign o_rsp.echo_address       = r_out.echo_address;
    assign o_rsp.echo_value         = r_out.echo_value;
    assign o_rsp.mbap_length        = r_out.mbap_length;
    assign o_rsp.reply_transaction  = r_out.reply_transaction;
    assign o_rsp.reply_unit         = r_out.reply_unit;
    assign o_rsp.register_word      = r_out.register_word;
    assign o_rsp.dirty_flag         = r_out.dirty_flag;
    assign o_rsp.is_last            = r_out.is_last;

    `MBRS_ASSERT_IMPL(a_data_rem, i_clk, i_rst_n, r_state == S_DATA, r_rem != '0)
    `MBRS_ASSERT_IMPL(a_data_read, i_clk, i_rst_n, w_out_load && r_state == S_DATA, r_job.op == mbrs_pkg::OP_READ)
    `MBRS_ASSERT_IMPL(a_dirty_set, i_clk, i_rst_n, $rose(r_dirty), $past(r_state == S_WCHK))
    `MBRS_ASSERT_IMPL(a_ptr_range, i_clk, i_rst_n, r_state == S_DATA, 32'(r_ptr) < REG_COUNT)

endmodule

@@ dv/modbus_reply_checker.sv @@
// Reply checker for the Modbus register server: predicts every reply and compares it.
module modbus_reply_checker #(
    parameter int N_REGS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mbrs_req_if  i_req,
    mbrs_cfg_if  i_cfg,
    mbrs_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // One accepted request or host command as seen on the request channel.
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [7:0]  unit_id;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] value;
        logic [15:0] tid;
        logic        wr;
    } t_request;

    // Shadow copy of the register table, the dirty flag and the configuration.
    logic [15:0] table_words    [N_REGS];
    logic        table_writable [N_REGS];
    logic        dirty;
    logic [7:0]  server_unit;
    logic [15:0] listen_port;

    // Replies predicted but not yet seen on the response channel, oldest first.
    mbrs_pkg::t_rsp pending_replies [$];
    int             reply_count;
    int             reported;

    // Counts a field mismatch and reports the first few of them.
    function automatic void note_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            o_fail_count++;
            if (reported < 10) begin
                reported++;
                $display("Reply %0d, field %s: expected 0x%0h, got 0x%0h",
                         reply_count, name, want, got);
            end
        end
    endfunction

    // Compares one reply transaction with the oldest prediction.
    function automatic void check_reply(mbrs_pkg::t_rsp got);
        mbrs_pkg::t_rsp want;
        if (pending_replies.size() == 0) begin
            o_fail_count++;
            if (reported < 10) begin
                reported++;
                $display("Reply %0d arrived with none expected: kind %0d function 0x%0h",
                         reply_count, got.item_kind, got.resp_function);
            end
        end else begin
            want = pending_replies.pop_front();
            note_field("item_kind", want.item_kind, got.item_kind);
            note_field("resp_function", want.resp_function, got.resp_function);
            note_field("count_or_exception", want.count_or_exception,
                       got.count_or_exception);
            note_field("echo_address", want.echo_address, got.echo_address);
            note_field("echo_value", want.echo_value, got.echo_value);
            note_field("mbap_length", want.mbap_length, got.mbap_length);
            note_field("reply_transaction", want.reply_transaction, got.reply_transaction);
            note_field("reply_unit", want.reply_unit, got.reply_unit);
            note_field("register_word", want.register_word, got.register_word);
            note_field("dirty_flag", want.dirty_flag, got.dirty_flag);
            note_field("is_last", want.is_last, got.is_last);
        end
        reply_count++;
    endfunction

    // Updates the shadow state for one request and queues the replies it causes.
    function automatic void predict_replies(t_request rq);
        mbrs_pkg::t_rsp hdr;
        mbrs_pkg::t_rsp word_item;
        logic [16:0]    span;
        logic [7:0]     exc;
        hdr                   = '0;
        hdr.item_kind         = mbrs_pkg::KIND_HEADER;
        hdr.reply_transaction = rq.tid;
        hdr.reply_unit        = rq.unit_id;
        hdr.is_last           = 1'b1;
        exc                   = mbrs_pkg::EXC_NONE;
        case (rq.cmd)
            mbrs_pkg::CMD_LOAD: begin
                if (rq.addr < N_REGS) begin
                    table_words[rq.addr]    = rq.value;
                    table_writable[rq.addr] = rq.wr;
                end
            end
            mbrs_pkg::CMD_CLEAR: begin
                dirty = 1'b0;
            end
            mbrs_pkg::CMD_NET: begin
                // Requests for another port or unit are dropped silently.
                if (rq.port != listen_port || rq.unit_id != server_unit) return;
                if (rq.func == mbrs_pkg::FN_READ_HOLDING ||
                    rq.func == mbrs_pkg::FN_READ_INPUT) begin
                    // The bounds check is done on the unwrapped sum.
                    span = {1'b0, rq.addr} + {1'b0, rq.value};
                    if (span <= N_REGS) begin
                        hdr.resp_function      = rq.func;
                        hdr.count_or_exception = 8'(rq.value * 2);
                        hdr.mbap_length        = mbrs_pkg::LEN_BASE + hdr.count_or_exception;
                        hdr.dirty_flag         = dirty;
                        hdr.is_last            = (rq.value == 0);
                        pending_replies.push_back(hdr);
                        for (int i = 0; i < int'(rq.value); i++) begin
                            word_item               = hdr;
                            word_item.item_kind     = mbrs_pkg::KIND_DATA;
                            word_item.register_word = table_words[int'(rq.addr) + i];
                            word_item.is_last       = (i + 1 == int'(rq.value));
                            pending_replies.push_back(word_item);
                        end
                    end else begin
                        exc = mbrs_pkg::EXC_ILLEGAL_ADDR;
                    end
                end else if (rq.func == mbrs_pkg::FN_WRITE_SINGLE) begin
                    if (rq.addr < N_REGS) begin
                        if (table_writable[rq.addr]) begin
                            table_words[rq.addr]   = rq.value;
                            dirty                  = 1'b1;
                            hdr.resp_function      = rq.func;
                            hdr.count_or_exception = mbrs_pkg::EXC_NONE;
                            hdr.echo_address       = rq.addr;
                            hdr.echo_value         = rq.value;
                            hdr.mbap_length        = mbrs_pkg::LEN_ECHO;
                            hdr.dirty_flag         = dirty;
                            pending_replies.push_back(hdr);
                        end else begin
                            exc = mbrs_pkg::EXC_ILLEGAL_FN;
                        end
                    end else begin
                        exc = mbrs_pkg::EXC_ILLEGAL_ADDR;
                    end
                end else begin
                    exc = mbrs_pkg::EXC_ILLEGAL_FN;
                end
                // Every refused network request answers with an exception header.
                if (exc != mbrs_pkg::EXC_NONE) begin
                    hdr.resp_function      = rq.func | mbrs_pkg::FN_EXC_BIT;
                    hdr.count_or_exception = exc;
                    hdr.mbap_length        = mbrs_pkg::LEN_EXC;
                    hdr.dirty_flag         = dirty;
                    pending_replies.push_back(hdr);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Watch all three channels; replies are checked before new requests are predicted.
    always @(posedge i_clk) begin
        t_request       rq;
        mbrs_pkg::t_rsp got;
        if (!i_rst_n) begin
            for (int i = 0; i < N_REGS; i++) begin
                table_words[i]    = '0;
                table_writable[i] = 1'b0;
            end
            dirty        = 1'b0;
            server_unit  = mbrs_pkg::UNIT_ID_RST;
            listen_port  = mbrs_pkg::LISTEN_PORT_RST;
            pending_replies.delete();
            reply_count  = 0;
            reported     = 0;
            o_fail_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.item_kind          = i_rsp.item_kind;
                got.resp_function      = i_rsp.resp_function;
                got.count_or_exception = i_rsp.count_or_exception;
                got.echo_address       = i_rsp.echo_address;
                got.echo_value         = i_rsp.echo_value;
                got.mbap_length        = i_rsp.mbap_length;
                got.reply_transaction  = i_rsp.reply_transaction;
                got.reply_unit         = i_rsp.reply_unit;
                got.register_word      = i_rsp.register_word;
                got.dirty_flag         = i_rsp.dirty_flag;
                got.is_last            = i_rsp.is_last;
                check_reply(got);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.reg_index == mbrs_pkg::CFG_UNIT_ID) begin
                    server_unit = i_cfg.wdata[7:0];
                end else if (i_cfg.reg_index == mbrs_pkg::CFG_LISTEN_PORT) begin
                    listen_port = i_cfg.wdata;
                end
            end
            if (i_req.valid && i_req.ready) begin
                rq.cmd     = i_req.cmd;
                rq.port    = i_req.dest_port;
                rq.unit_id = i_req.unit_ident;
                rq.func    = i_req.func_code;
                rq.addr    = i_req.start_address;
                rq.value   = i_req.value_or_quantity;
                rq.tid     = i_req.transaction_ident;
                rq.wr      = i_req.load_writable;
                predict_replies(rq);
            end
        end
        o_replies_due = pending_replies.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the Modbus register server testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_REGS          = 32;
    localparam int SETTLE_CYCLES   = 40;
    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int PHASE_COUNT     = 4;

    // Command code and register index that the block is expected to ignore.
    localparam logic [1:0]                     CMD_UNUSED    = 2'd3;
    localparam logic [mbrs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd15;

    // One request or host command to send.
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] dest_port;
        logic [7:0]  unit_ident;
        logic [7:0]  func_code;
        logic [15:0] start_address;
        logic [15:0] value;
        logic [15:0] tid;
        logic        wr;
    } t_request_item;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          replies_due;
    int          gap_max;
    int          stall_max;
    logic [7:0]  cur_slave;
    logic [15:0] cur_port;

    mbrs_req_if req_ch ();
    mbrs_cfg_if cfg_ch ();
    mbrs_rsp_if rsp_ch ();

    modbus_register_server #(
        .REG_COUNT(N_REGS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .i_cfg  (cfg_ch),
        .o_rsp  (rsp_ch)
    );

    modbus_reply_checker #(
        .N_REGS(N_REGS)
    ) reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_cfg        (cfg_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_replies_due(replies_due)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sends one request transaction after a random gap; returns at a falling edge.
    // Valid stays high afterwards so that back-to-back transactions need no toggle.
    task automatic send_request(input t_request_item it);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.cmd               = it.cmd;
        req_ch.dest_port         = it.dest_port;
        req_ch.unit_ident        = it.unit_ident;
        req_ch.func_code         = it.func_code;
        req_ch.start_address     = it.start_address;
        req_ch.value_or_quantity = it.value;
        req_ch.transaction_ident = it.tid;
        req_ch.load_writable     = it.wr;
        req_ch.valid             = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Builds and sends one directed request.
    task automatic issue(input logic [1:0] cmd, input logic [15:0] port,
                         input logic [7:0] unit_id, input logic [7:0] func,
                         input logic [15:0] addr, input logic [15:0] value,
                         input logic [15:0] tid, input logic wr);
        t_request_item it;
        it.cmd           = cmd;
        it.dest_port     = port;
        it.unit_ident    = unit_id;
        it.func_code     = func;
        it.start_address = addr;
        it.value         = value;
        it.tid           = tid;
        it.wr            = wr;
        send_request(it);
    endtask

    // Writes one configuration register; called at a falling edge.
    task automatic write_config(input logic [mbrs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] data);
        cfg_ch.reg_index = idx;
        cfg_ch.wdata     = data;
        cfg_ch.valid     = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stops sending, waits for every predicted reply, then lets in-flight host commands finish.
    task automatic settle();
        req_ch.valid = 1'b0;
        while (replies_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Draws one random request, mostly well-formed for the current configuration.
    function automatic t_request_item random_request();
        t_request_item it;
        int            pick;
        int            room;
        it.cmd           = mbrs_pkg::CMD_NET;
        it.dest_port     = 16'($urandom);
        it.unit_ident    = 8'($urandom);
        it.func_code     = 8'($urandom);
        it.start_address = 16'($urandom);
        it.value         = 16'($urandom);
        it.tid           = 16'($urandom);
        it.wr            = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            // Network request addressed to this server.
            it.dest_port  = cur_port;
            it.unit_ident = cur_slave;
            case ($urandom_range(0, 9))
                0, 1:       it.func_code = mbrs_pkg::FN_READ_HOLDING;
                2, 3:       it.func_code = mbrs_pkg::FN_READ_INPUT;
                4, 5, 6, 7: it.func_code = mbrs_pkg::FN_WRITE_SINGLE;
                default: begin
                end
            endcase
            if ($urandom_range(0, 4) != 0) begin
                it.start_address = 16'($urandom_range(0, N_REGS + 1));
            end
            if (it.func_code == mbrs_pkg::FN_READ_HOLDING ||
                it.func_code == mbrs_pkg::FN_READ_INPUT) begin
                // Mostly short reads, sometimes to the end of the table or one past it.
                room = N_REGS - int'(it.start_address);
                if (room >= 0) begin
                    case ($urandom_range(0, 9))
                        0:       it.value = 16'(room);
                        1:       it.value = 16'(room + 1);
                        2: begin
                        end
                        default: it.value = 16'($urandom_range(0, (room < 6) ? room : 6));
                    endcase
                end else begin
                    it.value = 16'($urandom_range(0, 3));
                end
            end
        end else if (pick < 75) begin
            // Host load, mostly in range and mostly writable.
            it.cmd = mbrs_pkg::CMD_LOAD;
            if ($urandom_range(0, 4) != 0) begin
                it.start_address = 16'($urandom_range(0, N_REGS + 1));
            end
            it.wr = ($urandom_range(0, 3) != 0);
        end else if (pick < 80) begin
            it.cmd = mbrs_pkg::CMD_CLEAR;
        end else if (pick < 90) begin
            // Request for another port or another unit.
            it.dest_port  = cur_port;
            it.unit_ident = cur_slave;
            if ($urandom_range(0, 1) != 0) begin
                it.dest_port = cur_port ^ 16'($urandom_range(1, 65535));
            end else begin
                it.unit_ident = cur_slave ^ 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 1) != 0) begin
                it.func_code = mbrs_pkg::FN_READ_HOLDING;
                it.value     = 16'($urandom_range(0, 4));
            end
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // Response side: random backpressure before each reply transaction.
    initial begin : reply_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    // Ends the run if no transaction completes on any channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main stimulus: reset, directed cases, then random phases under several configurations.
    initial begin : stimulus
        t_request_item it;
        int            counted;
        logic [7:0]    new_slave;
        logic [15:0]   new_port;

        i_rst_n                  = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.cmd               = mbrs_pkg::CMD_NET;
        req_ch.dest_port         = '0;
        req_ch.unit_ident        = '0;
        req_ch.func_code         = '0;
        req_ch.start_address     = '0;
        req_ch.value_or_quantity = '0;
        req_ch.transaction_ident = '0;
        req_ch.load_writable     = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.reg_index         = mbrs_pkg::CFG_UNIT_ID;
        cfg_ch.wdata             = '0;
        gap_max                  = 4;
        stall_max                = 4;
        cur_slave                = mbrs_pkg::UNIT_ID_RST;
        cur_port                 = mbrs_pkg::LISTEN_PORT_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed cases under the reset configuration.
        issue(mbrs_pkg::CMD_LOAD, 16'd0, 8'd0, 8'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1);
        issue(mbrs_pkg::CMD_LOAD, 16'd0, 8'd0, 8'd0, 16'd31, 16'h8001, 16'd1, 1'b0);
        issue(mbrs_pkg::CMD_LOAD, 16'd0, 8'd0, 8'd0, 16'd1, 16'h1234, 16'd2, 1'b1);
        // Host loads beyond the table are ignored.
        issue(mbrs_pkg::CMD_LOAD, 16'd0, 8'd0, 8'd0, 16'd32, 16'hDEAD, 16'd3, 1'b1);
        issue(mbrs_pkg::CMD_LOAD, 16'd0, 8'd0, 8'd0, 16'hFFFF, 16'hBEEF, 16'd4, 1'b1);
        // Full table read, a read at the end, and zero-length reads at and past the end.
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_HOLDING, 16'd0,
              16'd32, 16'hFFFF, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_INPUT, 16'd30,
              16'd2, 16'h0000, 1'b1);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_HOLDING, 16'd32,
              16'd0, 16'h1111, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_INPUT, 16'd33,
              16'd0, 16'h2222, 1'b0);
        // Reads past the end, including a sum that would wrap in 16 bits.
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_HOLDING, 16'd31,
              16'd2, 16'h3333, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_HOLDING, 16'hFFFF,
              16'hFFFF, 16'h4444, 1'b1);
        // Single writes: accepted, read-only, out of range.
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_WRITE_SINGLE, 16'd1,
              16'hA5A5, 16'h5555, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_WRITE_SINGLE, 16'd31,
              16'h5A5A, 16'h6666, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_WRITE_SINGLE, 16'd32,
              16'h0001, 16'h7777, 1'b0);
        // Unknown functions, two of them with the exception bit already set.
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, 8'h00, 16'd0, 16'd1, 16'h8888, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, 8'hFF, 16'd0, 16'd1, 16'h9999, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave,
              mbrs_pkg::FN_READ_HOLDING | mbrs_pkg::FN_EXC_BIT, 16'd0, 16'd1, 16'hAAAA, 1'b0);
        // Dropped requests and the unused command.
        issue(mbrs_pkg::CMD_NET, cur_port + 16'd1, cur_slave, mbrs_pkg::FN_READ_HOLDING,
              16'd0, 16'd1, 16'hBBBB, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, 8'd0, mbrs_pkg::FN_READ_HOLDING, 16'd0, 16'd1,
              16'hCCCC, 1'b0);
        issue(CMD_UNUSED, cur_port, cur_slave, mbrs_pkg::FN_READ_HOLDING, 16'd0, 16'd1,
              16'hDDDD, 1'b1);
        // Clear the dirty flag, read back the write, then write zero.
        issue(mbrs_pkg::CMD_CLEAR, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'hEEEE, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_READ_HOLDING, 16'd0,
              16'd2, 16'h0F0F, 1'b0);
        issue(mbrs_pkg::CMD_NET, cur_port, cur_slave, mbrs_pkg::FN_WRITE_SINGLE, 16'd0,
              16'd0, 16'hF0F0, 1'b1);

        // Random phases; each starts once the server has gone idle.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            case (ph)
                0: begin
                    new_slave = 8'h00;
                    new_port  = 16'h0000;
                    gap_max   = 4;
                    stall_max = 4;
                end
                1: begin
                    new_slave = 8'hFF;
                    new_port  = 16'hFFFF;
                    gap_max   = 0;
                    stall_max = 0;
                end
                2: begin
                    new_slave = 8'($urandom);
                    new_port  = 16'($urandom);
                    gap_max   = 0;
                    stall_max = 4;
                end
                default: begin
                    new_slave = mbrs_pkg::UNIT_ID_RST;
                    new_port  = mbrs_pkg::LISTEN_PORT_RST;
                    gap_max   = 4;
                    stall_max = 0;
                end
            endcase
            // Upper bits of the unit identifier write are not stored.
            write_config(mbrs_pkg::CFG_UNIT_ID, {8'($urandom), new_slave});
            write_config(mbrs_pkg::CFG_LISTEN_PORT, new_port);
            if (ph == 0) begin
                write_config(CFG_IDX_SPARE, 16'($urandom));
            end
            cur_slave = new_slave;
            cur_port  = new_port;
            counted   = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = random_request();
                counted++;
                send_request(it);
            end
        end

        settle();
        if (fail_count == 0 && replies_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
